[sv/lcal_pkg.sv]
package lcal_pkg;

    localparam int ID_W      = 11;
    localparam int FUNC_W    = 2;
    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int DEP_AW    = $clog2(MAX_NODES);
    localparam int JT_DEPTH  = MAX_NODES * LEVELS;
    localparam int JT_AW     = $clog2(JT_DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

    // memory request bundle from the sequencer
    typedef struct packed {
        logic                jt_we;
        logic [JT_AW-1:0]    jt_waddr;
        logic [ID_W-1:0]     jt_wdata;
        logic                dep_we;
        logic [DEP_AW-1:0]   dep_waddr;
        logic [ID_W-1:0]     dep_wdata;
        logic [JT_AW-1:0]    jt_raddr0;
        logic [JT_AW-1:0]    jt_raddr1;
        logic [DEP_AW-1:0]   dep_raddr0;
        logic [DEP_AW-1:0]   dep_raddr1;
    } lcal_mem_req_t;

    function automatic logic [DEP_AW-1:0] dep_addr(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] idm1;
        idm1 = id - ID_W'(1);
        return idm1[DEP_AW-1:0];
    endfunction

    function automatic logic [JT_AW-1:0] jt_addr(input logic [ID_W-1:0] id,
                                                 input logic [LVL_W-1:0] lvl);
        logic [DEP_AW-1:0] row;
        row = dep_addr(id);
        return JT_AW'(row) * JT_AW'(LEVELS) + JT_AW'(lvl);
    endfunction

    function automatic logic in_range(input logic [ID_W-1:0] id,
                                      input logic [ID_W-1:0] cnt);
        return (id != '0) && (id <= cnt);
    endfunction

endpackage

[sv/lcal_mem.sv]
module lcal_mem (
    input  logic                   aclk,
    input  lcal_pkg::lcal_mem_req_t req,
    output logic [lcal_pkg::ID_W-1:0] jt_q0,
    output logic [lcal_pkg::ID_W-1:0] jt_q1,
    output logic [lcal_pkg::ID_W-1:0] dep_q0,
    output logic [lcal_pkg::ID_W-1:0] dep_q1
);
    import lcal_pkg::*;

    logic [ID_W-1:0] jt_mem  [JT_DEPTH];
    logic [ID_W-1:0] dep_mem [MAX_NODES];

    // jump table: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (req.jt_we) begin
            jt_mem[req.jt_waddr] <= req.jt_wdata;
        end
        jt_q0 <= jt_mem[req.jt_raddr0];
        jt_q1 <= jt_mem[req.jt_raddr1];
    end

    // node depths
    always_ff @(posedge aclk) begin
        if (req.dep_we) begin
            dep_mem[req.dep_waddr] <= req.dep_wdata;
        end
        dep_q0 <= dep_mem[req.dep_raddr0];
        dep_q1 <= dep_mem[req.dep_raddr1];
    end

endmodule

[sv/lowest_common_ancestor_lifting_top.sv]
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------------
// input     | s_valid / s_ready       | s_func, s_node_a, s_node_b, s_parent_in, s_depth_in
// result    | m_valid / m_ready       | m_ancestor, m_bad_node
// config    | cfg_valid / cfg_ready   | cfg_data (node_count)
//
// Load and unused func leave the sequencer idle. A bad query goes through ST_RES to
// the output register. Query: a walk over the jump table, one level at a time,
// through the table's registered read ports.
// Build: two table reads per entry, over nodes 1..node_count and levels 1..LEVELS-1.
// aresetn (sync, active low) sets node_count to 1 and idles the sequencer; the
// tables are not cleared. s_ready is high only while idle; a finished result waits
// in the output register, and a later query stalls at its end until it drains.
module lowest_common_ancestor_lifting_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lcal_pkg::FUNC_W-1:0] s_func,
    input  logic [lcal_pkg::ID_W-1:0]   s_node_a,
    input  logic [lcal_pkg::ID_W-1:0]   s_node_b,
    input  logic [lcal_pkg::ID_W-1:0]   s_parent_in,
    input  logic [lcal_pkg::ID_W-1:0]   s_depth_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lcal_pkg::ID_W-1:0]   m_ancestor,
    output logic                        m_bad_node,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lcal_pkg::ID_W-1:0]   cfg_data
);
    import lcal_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_B_RD1  = 4'd1;
    localparam logic [3:0] ST_B_RD2  = 4'd2;
    localparam logic [3:0] ST_B_WR   = 4'd3;
    localparam logic [3:0] ST_Q_SWAP = 4'd4;
    localparam logic [3:0] ST_Q_L1J  = 4'd5;
    localparam logic [3:0] ST_Q_L1D  = 4'd6;
    localparam logic [3:0] ST_Q_FIX  = 4'd7;
    localparam logic [3:0] ST_Q_FIXR = 4'd8;
    localparam logic [3:0] ST_Q_CMP  = 4'd9;
    localparam logic [3:0] ST_Q_L2   = 4'd10;
    localparam logic [3:0] ST_Q_END  = 4'd11;
    localparam logic [3:0] ST_Q_ENDR = 4'd12;
    localparam logic [3:0] ST_RES    = 4'd13;

    // control
    logic [3:0]      state_reg, state_next;
    logic [ID_W-1:0] node_count_reg, node_count_next;
    logic            m_valid_reg, m_valid_next;

    // datapath
    logic [ID_W-1:0]  x_reg, x_next, y_reg, y_next, u_reg, u_next;
    logic [ID_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [ID_W-1:0]  idx_reg, idx_next;
    logic [ID_W-1:0]  res_anc_reg, res_anc_next;
    logic             res_bad_reg, res_bad_next;
    logic [ID_W-1:0]  m_ancestor_reg, m_ancestor_next;
    logic             m_bad_node_reg, m_bad_node_next;

    // probe ports: id presented this cycle, result next cycle
    logic [ID_W-1:0]  p0_id, p1_id;
    logic [LVL_W-1:0] p0_lvl, p1_lvl;
    logic [ID_W-1:0]  rd_id0_reg, rd_id1_reg;
    logic             rd_ok0_reg, rd_ok1_reg;

    lcal_mem_req_t   mreq;
    logic [ID_W-1:0] jt_q0, jt_q1, dep_q0, dep_q1;
    logic [ID_W-1:0] pv0, pv1, pd0, pd1;
    logic [ID_W-1:0] cnt_live;
    logic            s_fire;
    logic            take;
    logic [ID_W-1:0] xn, yn;

    lcal_mem u_mem (
        .aclk   (aclk),
        .req    (mreq),
        .jt_q0  (jt_q0),
        .jt_q1  (jt_q1),
        .dep_q0 (dep_q0),
        .dep_q1 (dep_q1)
    );

    assign cnt_live = (node_count_reg > ID_W'(MAX_NODES)) ? ID_W'(MAX_NODES) : node_count_reg;

    // out-of-range ids are their own ancestor with depth 0
    assign pv0 = rd_ok0_reg ? jt_q0  : rd_id0_reg;
    assign pv1 = rd_ok1_reg ? jt_q1  : rd_id1_reg;
    assign pd0 = rd_ok0_reg ? dep_q0 : '0;
    assign pd1 = rd_ok1_reg ? dep_q1 : '0;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_ancestor = m_ancestor_reg;
    assign m_bad_node = m_bad_node_reg;

    always_comb begin
        state_next      = state_reg;
        node_count_next = cfg_valid ? cfg_data : node_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ancestor_next = m_ancestor_reg;
        m_bad_node_next = m_bad_node_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        u_next          = u_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        res_anc_next    = res_anc_reg;
        res_bad_next    = res_bad_reg;
        p0_id           = x_reg;
        p0_lvl          = '0;
        p1_id           = y_reg;
        p1_lvl          = '0;
        take            = 1'b0;
        xn              = x_reg;
        yn              = y_reg;
        mreq            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_func)
                        FUNC_LOAD: begin
                            if (in_range(s_node_a, cnt_live)) begin
                                mreq.jt_we     = 1'b1;
                                mreq.jt_waddr  = jt_addr(s_node_a, '0);
                                mreq.jt_wdata  = s_parent_in;
                                mreq.dep_we    = 1'b1;
                                mreq.dep_waddr = dep_addr(s_node_a);
                                mreq.dep_wdata = s_depth_in;
                            end
                        end
                        FUNC_BUILD: begin
                            if ((cnt_live != '0) && (LEVELS > 1)) begin
                                idx_next   = ID_W'(1);
                                lvl_next   = LVL_W'(1);
                                state_next = ST_B_RD1;
                            end
                        end
                        FUNC_QUERY: begin
                            if (in_range(s_node_a, cnt_live) && in_range(s_node_b, cnt_live)) begin
                                x_next     = s_node_a;
                                y_next     = s_node_b;
                                p0_id      = s_node_a;
                                p1_id      = s_node_b;
                                state_next = ST_Q_SWAP;
                            end else begin
                                res_anc_next = '0;
                                res_bad_next = 1'b1;
                                state_next   = ST_RES;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // build: entry (i, j) = up(up(i, j-1), j-1)
            ST_B_RD1: begin
                p0_id      = idx_reg;
                p0_lvl     = lvl_reg - LVL_W'(1);
                state_next = ST_B_RD2;
            end
            ST_B_RD2: begin
                p0_id      = pv0;
                p0_lvl     = lvl_reg - LVL_W'(1);
                state_next = ST_B_WR;
            end
            ST_B_WR: begin
                mreq.jt_we    = 1'b1;
                mreq.jt_waddr = jt_addr(idx_reg, lvl_reg);
                mreq.jt_wdata = pv0;
                if (idx_reg == cnt_live) begin
                    if (lvl_reg == LAST_LVL) begin
                        state_next = ST_IDLE;
                    end else begin
                        // next level re-reads an entry written now: go via RD1
                        lvl_next   = lvl_reg + LVL_W'(1);
                        idx_next   = ID_W'(1);
                        state_next = ST_B_RD1;
                    end
                end else begin
                    idx_next   = idx_reg + ID_W'(1);
                    p0_id      = idx_reg + ID_W'(1);
                    p0_lvl     = lvl_reg - LVL_W'(1);
                    state_next = ST_B_RD2;
                end
            end

            // query, phase one: lift the deeper node
            ST_Q_SWAP: begin
                if (pd0 < pd1) begin
                    x_next  = y_reg;
                    y_next  = x_reg;
                    dx_next = pd1;
                    dy_next = pd0;
                    p0_id   = y_reg;
                end else begin
                    dx_next = pd0;
                    dy_next = pd1;
                    p0_id   = x_reg;
                end
                p0_lvl     = LAST_LVL;
                lvl_next   = LAST_LVL;
                state_next = ST_Q_L1J;
            end
            ST_Q_L1J: begin
                u_next     = pv0;
                p0_id      = pv0;
                state_next = ST_Q_L1D;
            end
            ST_Q_L1D: begin
                take = (pd0 >= dy_reg);
                xn   = take ? u_reg : x_reg;
                x_next = xn;
                if (take) begin
                    dx_next = pd0;
                end
                if (lvl_reg == '0) begin
                    state_next = ST_Q_FIX;
                end else begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    p0_id      = xn;
                    p0_lvl     = lvl_reg - LVL_W'(1);
                    state_next = ST_Q_L1J;
                end
            end
            ST_Q_FIX: begin
                // tree deeper than the levels reach: one more parent step
                if (dx_reg > dy_reg) begin
                    p0_id      = x_reg;
                    state_next = ST_Q_FIXR;
                end else begin
                    state_next = ST_Q_CMP;
                end
            end
            ST_Q_FIXR: begin
                x_next     = pv0;
                state_next = ST_Q_CMP;
            end

            // phase two: lift both while ancestors differ
            ST_Q_CMP: begin
                if (x_reg == y_reg) begin
                    res_anc_next = y_reg;
                    res_bad_next = 1'b0;
                    state_next   = ST_RES;
                end else begin
                    lvl_next   = LAST_LVL;
                    p0_lvl     = LAST_LVL;
                    p1_lvl     = LAST_LVL;
                    state_next = ST_Q_L2;
                end
            end
            ST_Q_L2: begin
                take   = (pv0 != pv1);
                xn     = take ? pv0 : x_reg;
                yn     = take ? pv1 : y_reg;
                x_next = xn;
                y_next = yn;
                if (lvl_reg == '0) begin
                    state_next = ST_Q_END;
                end else begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    p0_id      = xn;
                    p1_id      = yn;
                    p0_lvl     = lvl_reg - LVL_W'(1);
                    p1_lvl     = lvl_reg - LVL_W'(1);
                    state_next = ST_Q_L2;
                end
            end
            ST_Q_END: begin
                if (x_reg != y_reg) begin
                    state_next = ST_Q_ENDR;
                end else begin
                    res_anc_next = y_reg;
                    res_bad_next = 1'b0;
                    state_next   = ST_RES;
                end
            end
            ST_Q_ENDR: begin
                res_anc_next = pv1;
                res_bad_next = 1'b0;
                state_next   = ST_RES;
            end

            // hand off to the output register once it is free
            ST_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_ancestor_next = res_anc_reg;
                    m_bad_node_next = res_bad_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mreq.jt_raddr0  = jt_addr(p0_id, p0_lvl);
        mreq.jt_raddr1  = jt_addr(p1_id, p1_lvl);
        mreq.dep_raddr0 = dep_addr(p0_id);
        mreq.dep_raddr1 = dep_addr(p1_id);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= ID_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        u_reg          <= u_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        lvl_reg        <= lvl_next;
        idx_reg        <= idx_next;
        res_anc_reg    <= res_anc_next;
        res_bad_reg    <= res_bad_next;
        m_ancestor_reg <= m_ancestor_next;
        m_bad_node_reg <= m_bad_node_next;
        rd_id0_reg     <= p0_id;
        rd_id1_reg     <= p1_id;
        rd_ok0_reg     <= in_range(p0_id, cnt_live);
        rd_ok1_reg     <= in_range(p1_id, cnt_live);
    end

    // a flagged result always carries ancestor zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_node |-> m_ancestor == '0)
        else $error("bad_node result with nonzero ancestor");

    // build walk stays within the live node range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_RD1 || state_reg == ST_B_RD2 || state_reg == ST_B_WR)
        |-> (idx_reg != '0) && (idx_reg <= cnt_live) && (lvl_reg != '0))
        else $error("build index out of range");

    // an accepted query always leaves idle for its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_QUERY |=> state_reg != ST_IDLE)
        else $error("query transaction dropped");

endmodule
